// ===== src/crs_pkg.sv =====
// Shared types and constants for the chunked retransmit sender.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package crs_pkg;

  // Input opcodes (carried on s_tuser)
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_ACK  = 2'd2;

  // Result kinds (carried on m_tuser)
  localparam logic [1:0] KIND_FIRST = 2'd0;
  localparam logic [1:0] KIND_RETX  = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  localparam int unsigned TDATA_IN_W  = 16;
  localparam int unsigned TDATA_OUT_W = 88;

  // Message phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LOADING = 2'd1,
    PH_READY   = 2'd2
  } phase_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;        // input beat accepted
    logic scan_first;  // start a scan at chunk 0
    logic scan_adv;    // current chunk done, step to the next
    logic scan_emit;   // current chunk goes out
    logic flush;       // move held result to output as the final one
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic msg_ready;   // message complete
    logic has_chunks;  // at least one chunk
    logic need;        // current chunk must be sent
    logic scan_last;   // current chunk is the last one
    logic pend_valid;  // a result is held back
    logic out_free;    // output register can take a result
  } stat_t;

  // One result item without its last flag
  typedef struct packed {
    logic        ack_ignored;
    logic        all_acked;
    logic [63:0] chunk_data;
    logic [3:0]  chunk_len;
    logic [6:0]  msg_chunks;
    logic [5:0]  seq_num;
    logic [1:0]  kind;
  } res_t;

endpackage

`default_nettype wire

// ===== src/crs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module crs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/crs_ctrl.sv =====
// Controller state machine: input acceptance, chunk scan, final flush.
// Depends on crs_pkg.
`default_nettype none

module crs_ctrl
  import crs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] opcode,
  input  wire stat_t      st,
  output logic            in_ready,
  output cmd_t            cmd
);

  state_t state;
  state_t state_next;
  logic   can_go;

  // A chunk may proceed when it needs no send or the held result can move on
  assign can_go = !st.need || !st.pend_valid || st.out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_ACK) begin
            state_next = ST_FLUSH;
          end else if (opcode == OP_TICK && st.msg_ready && st.has_chunks) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (can_go && st.scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!st.pend_valid || st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.take       = in_valid;
        cmd.scan_first = in_valid && opcode == OP_TICK && st.msg_ready && st.has_chunks;
      end
      ST_SCAN: begin
        cmd.scan_adv  = can_go;
        cmd.scan_emit = can_go && st.need;
      end
      ST_FLUSH: begin
        cmd.flush = st.pend_valid && st.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/crs_datapath.sv =====
// Datapath: message rows, chunk marks, send stamps, tick counter, result registers.
// Depends on crs_pkg and crs_ram.
`default_nettype none

module crs_datapath
  import crs_pkg::*;
#(
  parameter int unsigned MAX_CHUNK_COUNT = 32,
  parameter int unsigned CHUNK_BYTES     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output stat_t            st,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  data_byte,
  input  wire logic        is_last_byte,
  input  wire logic [7:0]  ack_seq,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        out_ready,
  output logic             out_valid,
  output res_t             out_res,
  output logic             out_last
);

  localparam int unsigned IW = (MAX_CHUNK_COUNT > 1) ? $clog2(MAX_CHUNK_COUNT) : 1;
  localparam int unsigned CW = $clog2(MAX_CHUNK_COUNT + 1);
  localparam int unsigned FW = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned RW = CHUNK_BYTES * 8;

  // Message and mark state
  phase_t                     phase;
  logic [CW-1:0]              n_chunks;
  logic [FW-1:0]              fill;
  logic [RW-1:0]              row_buf;
  logic [MAX_CHUNK_COUNT-1:0] sent;
  logic [MAX_CHUNK_COUNT-1:0] acked;
  logic [CW-1:0]              acked_count;
  logic [31:0]                tick_count;
  logic [15:0]                timeout_ticks;
  logic [IW-1:0]              idx;
  logic                       pend_valid;
  res_t                       pend;

  // Byte loading
  logic          is_byte, is_tick, is_ack;
  logic          new_msg, new_row, drop;
  logic [CW-1:0] n_base;
  logic [RW-1:0] row_buf_next;
  logic          row_we;
  logic [IW-1:0] row_waddr;

  // Scan
  logic [IW-1:0] rd_addr;
  logic [RW-1:0] row_rd;
  logic [31:0]   stamp_rd;
  logic [31:0]   age;
  logic          timed_out;
  res_t          chunk_res;

  // Ack
  logic          ack_ok;
  logic [IW-1:0] ack_idx;
  logic          ack_new;
  logic [CW-1:0] acked_after;
  res_t          ack_res;
  logic          out_free;

  assign is_byte = cmd.take && opcode == OP_BYTE;
  assign is_tick = cmd.take && opcode == OP_TICK;
  assign is_ack  = cmd.take && opcode == OP_ACK;

  // Place an incoming byte into the current row or open a new one
  assign new_msg = phase != PH_LOADING;
  assign n_base  = new_msg ? '0 : n_chunks;
  assign drop    = !new_msg && n_chunks == CW'(MAX_CHUNK_COUNT) && fill == FW'(CHUNK_BYTES);
  assign new_row = new_msg || n_chunks == '0 || fill == FW'(CHUNK_BYTES);

  always_comb begin
    row_buf_next = row_buf;
    if (new_row) begin
      row_buf_next = RW'(data_byte);
    end else begin
      for (int b = 0; b < CHUNK_BYTES; b++) begin
        if (fill == FW'(b)) begin
          row_buf_next[8*b +: 8] = data_byte;
        end
      end
    end
  end

  assign row_we    = is_byte && !drop;
  assign row_waddr = new_row ? IW'(n_base) : IW'(n_base - CW'(1));

  // Chunk read address is the next value of the scan index, so the registered read matches it
  assign rd_addr = cmd.scan_first ? '0 : (cmd.scan_adv ? idx + IW'(1) : idx);

  crs_ram #(.WIDTH(RW), .DEPTH(MAX_CHUNK_COUNT)) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_buf_next),
    .raddr (rd_addr),
    .rdata (row_rd)
  );

  crs_ram #(.WIDTH(32), .DEPTH(MAX_CHUNK_COUNT)) u_stamps (
    .clk   (clk),
    .we    (cmd.scan_emit),
    .waddr (idx),
    .wdata (tick_count),
    .raddr (rd_addr),
    .rdata (stamp_rd)
  );

  // Decide on the chunk under the scan index
  assign age       = tick_count - stamp_rd;
  assign timed_out = age > {16'd0, timeout_ticks};

  always_comb begin
    chunk_res            = '0;
    chunk_res.kind       = sent[idx] ? KIND_RETX : KIND_FIRST;
    chunk_res.seq_num    = 6'(idx);
    chunk_res.msg_chunks = 7'(n_chunks);
    chunk_res.chunk_len  = st.scan_last ? 4'(fill) : 4'(CHUNK_BYTES);
    chunk_res.chunk_data = 64'(row_rd);
  end

  // Acknowledgement status
  assign ack_ok      = phase == PH_READY && ack_seq < 8'(n_chunks);
  assign ack_idx     = IW'(ack_seq);
  assign ack_new     = ack_ok && !acked[ack_idx];
  assign acked_after = acked_count + CW'(ack_new);

  always_comb begin
    ack_res             = '0;
    ack_res.kind        = KIND_ACK;
    ack_res.seq_num     = ack_seq[5:0];
    ack_res.msg_chunks  = 7'(n_chunks);
    ack_res.all_acked   = n_chunks == '0 || (phase == PH_READY && acked_after == n_chunks);
    ack_res.ack_ignored = !ack_ok;
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    st.msg_ready  = phase == PH_READY;
    st.has_chunks = n_chunks != '0;
    st.need       = !acked[idx] && (!sent[idx] || timed_out);
    st.scan_last  = CW'(idx) == n_chunks - CW'(1);
    st.pend_valid = pend_valid;
    st.out_free   = out_free;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      n_chunks      <= '0;
      fill          <= '0;
      sent          <= '0;
      acked         <= '0;
      acked_count   <= '0;
      tick_count    <= '0;
      timeout_ticks <= 16'd10;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_data;
      end
      // Load a message byte
      if (is_byte) begin
        if (new_msg) begin
          sent        <= '0;
          acked       <= '0;
          acked_count <= '0;
        end
        if (row_we) begin
          if (new_row) begin
            n_chunks <= n_base + CW'(1);
            fill     <= FW'(1);
          end else begin
            n_chunks <= n_base;
            fill     <= fill + FW'(1);
          end
        end
        phase <= is_last_byte ? PH_READY : PH_LOADING;
      end
      if (is_tick) begin
        tick_count <= tick_count + 32'd1;
      end
      // Mark acknowledged chunk
      if (is_ack && ack_new) begin
        acked[ack_idx] <= 1'b1;
        acked_count    <= acked_after;
      end
      if (cmd.scan_emit) begin
        sent[idx] <= 1'b1;
      end
      // Held result slot
      if (is_ack || cmd.scan_emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      // Output register
      if ((cmd.scan_emit && pend_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (is_byte && row_we) begin
      row_buf <= row_buf_next;
    end
    if (cmd.scan_first) begin
      idx <= '0;
    end else if (cmd.scan_adv) begin
      idx <= idx + IW'(1);
    end
    if (is_ack) begin
      pend <= ack_res;
    end else if (cmd.scan_emit) begin
      pend <= chunk_res;
    end
    if ((cmd.scan_emit && pend_valid) || cmd.flush) begin
      out_res  <= pend;
      out_last <= cmd.flush;
    end
  end

endmodule

`default_nettype wire

// ===== src/chunked_retransmit_sender_core.sv =====
// Chunked retransmit sender: top level joining controller and datapath.
// A byte beat is taken while idle; an ack beat's status result passes through the held
// result register and the output register. A tick scans one chunk slot per cycle while no
// held result waits on a stalled output; no input beat is taken until scan and flush end.
// Reset: synchronous rst clears phase, marks, counters and valids; memories are not cleared.
// Depends on crs_pkg, crs_ctrl, crs_datapath.
`default_nettype none

module chunked_retransmit_sender_core
  import crs_pkg::*;
#(
  parameter int unsigned MAX_CHUNK_COUNT = 32,
  parameter int unsigned CHUNK_BYTES     = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // config: timeout_ticks
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [15:0]            cfg_data,
  // input stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // data_byte[7:0], ack_seq[15:8]
  input  wire logic [1:0]             s_tuser,   // opcode[1:0]
  input  wire logic                   s_tlast,   // is_last_byte
  // output stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [TDATA_OUT_W-1:0]      m_tdata,   // seq_num[5:0], msg_chunks[12:6],
                                                 // chunk_len[16:13], chunk_data[80:17],
                                                 // all_acked[81], ack_ignored[82], zero[87:83]
  output logic [1:0]                  m_tuser,   // kind[1:0]
  output logic                        m_tlast    // last
);

  cmd_t  cmd;
  stat_t st;
  res_t  out_res;

  assign cfg_ready = 1'b1;

  crs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .opcode   (s_tuser),
    .st       (st),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  crs_datapath #(
    .MAX_CHUNK_COUNT (MAX_CHUNK_COUNT),
    .CHUNK_BYTES     (CHUNK_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .opcode       (s_tuser),
    .data_byte    (s_tdata[7:0]),
    .is_last_byte (s_tlast),
    .ack_seq      (s_tdata[15:8]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_res      (out_res),
    .out_last     (m_tlast)
  );

  // Pack the result beat
  assign m_tuser = out_res.kind;
  assign m_tdata = {5'd0, out_res.ack_ignored, out_res.all_acked, out_res.chunk_data,
                    out_res.chunk_len, out_res.msg_chunks, out_res.seq_num};

  // The held result slot is empty whenever new input is taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !st.pend_valid)
    else $error("input accepted while a result is still held");

  // A held result is never overwritten while the output is blocked
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_emit && st.pend_valid) |-> st.out_free)
    else $error("held result pushed into a busy output register");

  // Flush only moves a real result
  a_flush_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> (st.pend_valid && st.out_free))
    else $error("flush without a held result");

  // A flushed result appears as the final beat
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> (m_tvalid && m_tlast))
    else $error("flushed result not marked last");

endmodule

`default_nettype wire

// ===== tb/chunked_retransmit_sender_core_tb.sv =====
// Self-checking bench for chunked_retransmit_sender_core: directed table, then random sessions.
// Predicts result beats from its own copy of the sender state; needs crs_pkg and the core.
`timescale 1ns / 1ps

module chunked_retransmit_sender_core_tb;
  import crs_pkg::*;

  localparam int SLOT_COUNT  = 32;
  localparam int CHUNK_BYTES = 8;
  localparam int STORE_BYTES = SLOT_COUNT * CHUNK_BYTES;
  localparam int SCAN_SLACK  = 2 * SLOT_COUNT + 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [15:0] TIMEOUT_AT_RESET = 16'd10;

  typedef enum int {RX_OPEN, RX_PATTERN, RX_SPARSE, RX_BUSY} rx_mode_t;

  // One input beat, optionally with its status result typed in by hand
  typedef struct {
    logic [1:0] op;
    logic [7:0] dbyte;
    logic       lastb;
    logic [7:0] aseq;
    bit         typed;
    res_t       want;
  } item_t;

  typedef struct {
    res_t r;
    bit   fin;
  } beat_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [15:0]            cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata;   // data_byte[7:0], ack_seq[15:8]
  logic [1:0]             s_tuser;   // opcode[1:0]
  logic                   s_tlast;   // is_last_byte
  logic                   m_tvalid;
  logic                   m_tready;
  logic [TDATA_OUT_W-1:0] m_tdata;   // seq_num, msg_chunks, chunk_len, chunk_data,
                                     // all_acked, ack_ignored, zero pad
  logic [1:0]             m_tuser;   // kind[1:0]
  logic                   m_tlast;   // last

  chunked_retransmit_sender_core #(
    .MAX_CHUNK_COUNT(SLOT_COUNT),
    .CHUNK_BYTES    (CHUNK_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Sender state as the bench sees it
  logic [7:0]            msg_bytes [0:STORE_BYTES-1];
  int                    msg_len = 0;
  phase_t                ph = PH_IDLE;
  bit [SLOT_COUNT-1:0]   sent_mask = '0;
  bit [SLOT_COUNT-1:0]   acked_mask = '0;
  logic [31:0]           stamps [0:SLOT_COUNT-1];
  logic [31:0]           tick_count = '0;
  logic [15:0]           timeout_reg = TIMEOUT_AT_RESET;

  beat_t owed_results[$];
  item_t stim_rows[$];
  item_t cur_item;
  int    err_count = 0;
  int    burst_left = 0;
  int    items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    err_count++;
    if (err_count <= 40)
      $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  function automatic logic [6:0] chunk_count();
    return 7'((msg_len + CHUNK_BYTES - 1) / CHUNK_BYTES);
  endfunction

  function automatic res_t build_send(input logic [1:0] kind, input int idx);
    res_t r;
    int   base;
    int   size;
    r = '0;
    base = idx * CHUNK_BYTES;
    size = msg_len - base;
    if (size > CHUNK_BYTES) size = CHUNK_BYTES;
    r.kind       = kind;
    r.seq_num    = idx[5:0];
    r.msg_chunks = chunk_count();
    r.chunk_len  = size[3:0];
    for (int b = 0; b < size; b++) r.chunk_data[8*b +: 8] = msg_bytes[base + b];
    return r;
  endfunction

  // Advance the sender state by one accepted beat and queue the results it owes
  task automatic step_sender(input logic [1:0] op, input logic [7:0] dbyte,
                             input logic lastb, input logic [7:0] aseq);
    int          n0;
    int          n;
    bit          done;
    bit          ign;
    logic [31:0] age;
    beat_t       bt;
    n0 = owed_results.size();
    case (op)
      OP_BYTE: begin
        if (ph != PH_LOADING) begin
          msg_len = 0;
          sent_mask = '0;
          acked_mask = '0;
          ph = PH_LOADING;
        end
        if (msg_len < STORE_BYTES) begin
          msg_bytes[msg_len] = dbyte;
          msg_len++;
        end
        if (lastb) ph = PH_READY;
      end
      OP_TICK: begin
        tick_count = tick_count + 32'd1;
        if (ph == PH_READY) begin
          n = int'(chunk_count());
          for (int i = 0; i < n && i < SLOT_COUNT; i++) begin
            if (acked_mask[i]) continue;
            age = tick_count - stamps[i];
            bt.fin = 1'b0;
            if (!sent_mask[i]) begin
              bt.r = build_send(KIND_FIRST, i);
              owed_results.push_back(bt);
              sent_mask[i] = 1'b1;
              stamps[i] = tick_count;
            end else if (age > {16'd0, timeout_reg}) begin
              bt.r = build_send(KIND_RETX, i);
              owed_results.push_back(bt);
              stamps[i] = tick_count;
            end
          end
        end
      end
      OP_ACK: begin
        n = int'(chunk_count());
        ign = !(ph == PH_READY && aseq < n && aseq < SLOT_COUNT);
        if (!ign) acked_mask[aseq] = 1'b1;
        if (n == 0) done = 1'b1;
        else if (ph != PH_READY) done = 1'b0;
        else begin
          done = 1'b1;
          for (int i = 0; i < n && i < SLOT_COUNT; i++)
            if (!acked_mask[i]) done = 1'b0;
        end
        bt.r = '0;
        bt.r.kind = KIND_ACK;
        bt.r.seq_num = aseq[5:0];
        bt.r.msg_chunks = 7'(n);
        bt.r.all_acked = done;
        bt.r.ack_ignored = ign;
        bt.fin = 1'b0;
        owed_results.push_back(bt);
      end
      default: ;
    endcase
    // Flag the final beat of this input
    if (owed_results.size() > n0) begin
      bt = owed_results.pop_back();
      bt.fin = 1'b1;
      owed_results.push_back(bt);
    end
  endtask

  // Check output beats and predict on accepted input beats
  always @(posedge clk) begin : watch
    res_t  got;
    beat_t want;
    int    n0;
    if (rst === 1'b0) begin
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        got = {m_tdata[82:0], m_tuser};
        if (owed_results.size() == 0) begin
          report_mismatch("beat with nothing owed", 64'd0, got.chunk_data);
        end else begin
          want = owed_results.pop_front();
          if (got.kind !== want.r.kind)
            report_mismatch("kind", 64'(want.r.kind), 64'(got.kind));
          if (got.seq_num !== want.r.seq_num)
            report_mismatch("seq_num", 64'(want.r.seq_num), 64'(got.seq_num));
          if (got.msg_chunks !== want.r.msg_chunks)
            report_mismatch("msg_chunks", 64'(want.r.msg_chunks), 64'(got.msg_chunks));
          if (got.chunk_len !== want.r.chunk_len)
            report_mismatch("chunk_len", 64'(want.r.chunk_len), 64'(got.chunk_len));
          if (got.chunk_data !== want.r.chunk_data)
            report_mismatch("chunk_data", want.r.chunk_data, got.chunk_data);
          if (got.all_acked !== want.r.all_acked)
            report_mismatch("all_acked", 64'(want.r.all_acked), 64'(got.all_acked));
          if (got.ack_ignored !== want.r.ack_ignored)
            report_mismatch("ack_ignored", 64'(want.r.ack_ignored), 64'(got.ack_ignored));
          if (m_tlast !== want.fin)
            report_mismatch("last", 64'(want.fin), 64'(m_tlast));
        end
      end
      if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
        n0 = owed_results.size();
        step_sender(cur_item.op, cur_item.dbyte, cur_item.lastb, cur_item.aseq);
        // Hand-typed rows replace the predicted beats
        if (cur_item.typed) begin
          while (owed_results.size() > n0) void'(owed_results.pop_back());
          if (cur_item.op == OP_ACK) begin
            want.r = cur_item.want;
            want.fin = 1'b1;
            owed_results.push_back(want);
          end
        end
      end
    end
  end

  // Receiver: ready follows a random mode that is redrawn after a random hold
  initial begin : receiver
    rx_mode_t    rx_mode;
    int          hold_left;
    logic [15:0] rx_pattern;
    m_tready = 1'b0;
    hold_left = 0;
    rx_mode = RX_OPEN;
    rx_pattern = '1;
    forever begin
      if (hold_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        hold_left = $urandom_range(20, 80);
        rx_pattern = 16'($urandom);
      end
      hold_left--;
      @(negedge clk);
      case (rx_mode)
        RX_OPEN: m_tready <= 1'b1;
        RX_PATTERN: begin
          m_tready <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic item_t make_item(input logic [1:0] op, input logic [7:0] dbyte,
                                      input logic lastb, input logic [7:0] aseq);
    item_t it;
    it.op = op;
    it.dbyte = dbyte;
    it.lastb = lastb;
    it.aseq = aseq;
    it.typed = 1'b0;
    it.want = '0;
    return it;
  endfunction

  task automatic add_row(input logic [1:0] op, input logic [7:0] dbyte, input logic lastb,
                         input logic [7:0] aseq, input bit typed, input logic [6:0] total,
                         input bit all, input bit ign);
    item_t it;
    it = make_item(op, dbyte, lastb, aseq);
    it.typed = typed;
    it.want.kind = KIND_ACK;
    it.want.seq_num = aseq[5:0];
    it.want.msg_chunks = total;
    it.want.all_acked = all;
    it.want.ack_ignored = ign;
    stim_rows.push_back(it);
  endtask

  // Drive one input beat, in bursts with random gaps, and hold until accepted
  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cur_item = it;
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {it.aseq, it.dbyte};
    s_tlast  <= it.lastb;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    if (it.op != OP_UNUSED) items_sent++;
  endtask

  // Drop valid, wait for every owed beat, then let a full scan run out
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SCAN_SLACK) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    timeout_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One message load followed by ticks and acks, with some noise mixed in
  task automatic run_session();
    int len;
    int total;
    int nops;
    int r;
    bit broken;
    r = $urandom_range(0, 99);
    if (r < 80) len = $urandom_range(1, 16);
    else len = $urandom_range(17, 48);
    broken = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < len; k++)
      send_item(make_item(OP_BYTE, 8'($urandom), (k == len - 1) && !broken, 8'($urandom)));
    total = (len + CHUNK_BYTES - 1) / CHUNK_BYTES;
    nops = $urandom_range(3, 12);
    for (int k = 0; k < nops; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        send_item(make_item(OP_TICK, 8'($urandom), 1'($urandom), 8'($urandom)));
      else if (r < 88)
        send_item(make_item(OP_ACK, 8'($urandom), 1'($urandom),
                            8'($urandom_range(0, total - 1))));
      else if (r < 93)
        send_item(make_item(OP_ACK, 8'($urandom), 1'($urandom), 8'($urandom)));
      else if (r < 97)
        send_item(make_item(OP_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom)));
      else
        send_item(make_item(OP_BYTE, 8'($urandom), 1'($urandom), 8'($urandom)));
    end
  endtask

  initial begin : main
    int start;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_BYTE;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows: empty message, unused opcode, acks out of range, short last chunk,
    // repeated ack, restart while ready. Typed rows carry their status by hand.
    add_row(OP_ACK,    8'h00, 1'b0, 8'h00, 1, 7'd0, 1, 1);
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, 1, 7'd0, 0, 0);
    add_row(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, 1, 7'd0, 0, 0);
    add_row(OP_ACK,    8'h00, 1'b0, 8'hFF, 1, 7'd0, 1, 1);
    add_row(OP_BYTE,   8'h00, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_ACK,    8'h00, 1'b0, 8'h00, 1, 7'd1, 0, 1);
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, 1, 7'd0, 0, 0);
    add_row(OP_BYTE,   8'hFF, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_BYTE,   8'hA5, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_BYTE,   8'h5A, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_BYTE,   8'h01, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_BYTE,   8'h80, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_BYTE,   8'h7E, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_BYTE,   8'h81, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_BYTE,   8'hC3, 1'b1, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_ACK,    8'h00, 1'b0, 8'h01, 0, 7'd0, 0, 0);
    add_row(OP_ACK,    8'h00, 1'b0, 8'h02, 1, 7'd2, 0, 1);
    add_row(OP_ACK,    8'h00, 1'b0, 8'h01, 0, 7'd0, 0, 0);
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_ACK,    8'h00, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_BYTE,   8'h42, 1'b1, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    add_row(OP_ACK,    8'h00, 1'b0, 8'h40, 1, 7'd1, 0, 1);
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, 0, 7'd0, 0, 0);
    foreach (stim_rows[i]) send_item(stim_rows[i]);
    settle();

    // Random phases; the timeout is rewritten before each phase after the first
    for (int p = 0; p < 5; p++) begin
      case (p)
        1: write_timeout(16'd1);
        2: write_timeout(16'hFFFF);
        3: write_timeout(16'($urandom_range(2, 24)));
        4: write_timeout(TIMEOUT_AT_RESET);
        default: ;
      endcase
      start = items_sent;
      run_session();
      while (items_sent - start < 16) run_session();
      settle();
    end

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/crs_pkg.sv
src/crs_ram.sv
src/crs_ctrl.sv
src/crs_datapath.sv
src/chunked_retransmit_sender_core.sv
tb/chunked_retransmit_sender_core_tb.sv
